[design/extended_gcd_inverse_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the extended GCD inverse unit
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef EXTENDED_GCD_INVERSE_UNIT_MACROS_SVH
`define EXTENDED_GCD_INVERSE_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset.
`define EGCD_ASSERT_IMP(lbl, clk, rst, ant, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
      else $error("egcd assertion failed");

// Next-cycle implication, disabled during reset.
`define EGCD_ASSERT_NXT(lbl, clk, rst, ant, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
      else $error("egcd assertion failed");

`else

`define EGCD_ASSERT_IMP(lbl, clk, rst, ant, cons)
`define EGCD_ASSERT_NXT(lbl, clk, rst, ant, cons)

`endif

`endif

[design/egcd_pkg.sv]
// ----------------------------------------------------------------------------
// egcd_pkg
// Widths and controller/datapath command types for the extended GCD unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package egcd_pkg;

   // Operand width used by the arithmetic.
   localparam int WIDTH        = 32;
   // Coefficient width: operand width plus a sign bit.
   localparam int COEF_W       = WIDTH + 1;
   // Widths of the item fields on the channels.
   localparam int FIELD_W      = 32;
   localparam int COEF_FIELD_W = 33;
   // Division step counter width.
   localparam int CNT_W        = $clog2(WIDTH);

   typedef struct packed {
      logic load;      // capture a new item and order the operands
      logic div_init;  // clear the divider for a new quotient
      logic div_step;  // one restoring division step
      logic update;    // close one Euclid iteration
      logic out_load;  // fold coefficients into the output register
   } cmd_type;

   typedef struct packed {
      logic lo_zero;   // smaller operand has reached zero
   } status_type;

endpackage

`default_nettype wire

[design/egcd_channels.sv]
// ----------------------------------------------------------------------------
// egcd channel interfaces
// Valid/ready channels carrying request and response items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface egcd_req_if;
   logic                             valid;
   logic                             ready;
   logic [egcd_pkg::FIELD_W-1:0]     operand_a;
   logic [egcd_pkg::FIELD_W-1:0]     operand_b;

   modport source (output valid, output operand_a, output operand_b, input ready);
   modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface egcd_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic        [egcd_pkg::FIELD_W-1:0]      gcd_value;
   logic signed [egcd_pkg::COEF_FIELD_W-1:0] coeff_a;
   logic signed [egcd_pkg::COEF_FIELD_W-1:0] coeff_b;

   modport source (output valid, output gcd_value, output coeff_a, output coeff_b,
                   input ready);
   modport sink   (input valid, input gcd_value, input coeff_a, input coeff_b,
                   output ready);
endinterface

`default_nettype wire

[design/egcd_datapath.sv]
// ----------------------------------------------------------------------------
// egcd_datapath
// Operand, remainder and coefficient registers with a bit-serial divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module egcd_datapath (
   input  wire logic                                    clock,
   input  wire logic        [egcd_pkg::FIELD_W-1:0]      operand_a,
   input  wire logic        [egcd_pkg::FIELD_W-1:0]      operand_b,
   input  wire egcd_pkg::cmd_type                        cmd,
   output egcd_pkg::status_type                          status,
   output logic             [egcd_pkg::FIELD_W-1:0]      gcd_value,
   output logic signed      [egcd_pkg::COEF_FIELD_W-1:0] coeff_a,
   output logic signed      [egcd_pkg::COEF_FIELD_W-1:0] coeff_b
);

   localparam int W = egcd_pkg::WIDTH;
   localparam int C = egcd_pkg::COEF_W;

   logic [W-1:0] hi_ff, hi_in, lo_ff, lo_in, b_ff, b_in;
   logic [W-1:0] rem_ff, rem_in, dvd_ff, dvd_in;
   logic [C-1:0] up_ff, up_in, uc_ff, uc_in, vp_ff, vp_in, vc_ff, vc_in;
   logic [C-1:0] pu_ff, pu_in, pv_ff, pv_in;
   logic         swap_ff, swap_in;
   logic [egcd_pkg::FIELD_W-1:0]      gcd_ff, gcd_in;
   logic [egcd_pkg::COEF_FIELD_W-1:0] ca_ff, ca_in, cb_ff, cb_in;

   logic [W-1:0] a_op, b_op;
   logic [W:0]   rem_sh, rem_sub;
   logic         q_bit;
   logic [C-1:0] ca_sel, cb_sel, ca_fix;

   assign a_op = operand_a[W-1:0];
   assign b_op = operand_b[W-1:0];

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   assign rem_sh  = {rem_ff, dvd_ff[W-1]};
   assign q_bit   = (rem_sh >= {1'b0, lo_ff});
   assign rem_sub = rem_sh - {1'b0, lo_ff};

   // Coefficients of the original operands, swapped back if needed.
   assign ca_sel = swap_ff ? vp_ff : up_ff;
   assign cb_sel = swap_ff ? up_ff : vp_ff;
   assign ca_fix = ca_sel[C-1] ? (ca_sel + {{(C-W){1'b0}}, b_ff}) : ca_sel;

   always_comb begin
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      b_in    = b_ff;
      swap_in = swap_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      up_in   = up_ff;
      uc_in   = uc_ff;
      vp_in   = vp_ff;
      vc_in   = vc_ff;
      pu_in   = pu_ff;
      pv_in   = pv_ff;
      gcd_in  = gcd_ff;
      ca_in   = ca_ff;
      cb_in   = cb_ff;

      if (cmd.load) begin
         b_in    = b_op;
         swap_in = !(a_op > b_op);
         hi_in   = (a_op > b_op) ? a_op : b_op;
         lo_in   = (a_op > b_op) ? b_op : a_op;
         up_in   = C'(1);
         uc_in   = '0;
         vp_in   = '0;
         vc_in   = C'(1);
      end

      if (cmd.div_init) begin
         rem_in = '0;
         dvd_in = hi_ff;
         pu_in  = '0;
         pv_in  = '0;
      end

      if (cmd.div_step) begin
         rem_in = q_bit ? rem_sub[W-1:0] : rem_sh[W-1:0];
         dvd_in = {dvd_ff[W-2:0], 1'b0};
         // Quotient bits arrive MSB first, so q*coef builds up Horner style.
         pu_in  = {pu_ff[C-2:0], 1'b0} + (q_bit ? uc_ff : '0);
         pv_in  = {pv_ff[C-2:0], 1'b0} + (q_bit ? vc_ff : '0);
      end

      if (cmd.update) begin
         hi_in = lo_ff;
         lo_in = rem_ff;
         up_in = uc_ff;
         uc_in = up_ff - pu_ff;
         vp_in = vc_ff;
         vc_in = vp_ff - pv_ff;
      end

      if (cmd.out_load) begin
         gcd_in = egcd_pkg::FIELD_W'(hi_ff);
         ca_in  = egcd_pkg::COEF_FIELD_W'($signed(ca_fix));
         cb_in  = egcd_pkg::COEF_FIELD_W'($signed(cb_sel));
      end
   end

   always_ff @(posedge clock) begin
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      b_ff    <= b_in;
      swap_ff <= swap_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      up_ff   <= up_in;
      uc_ff   <= uc_in;
      vp_ff   <= vp_in;
      vc_ff   <= vc_in;
      pu_ff   <= pu_in;
      pv_ff   <= pv_in;
      gcd_ff  <= gcd_in;
      ca_ff   <= ca_in;
      cb_ff   <= cb_in;
   end

   assign status.lo_zero = (lo_ff == '0);
   assign gcd_value      = gcd_ff;
   assign coeff_a        = $signed(ca_ff);
   assign coeff_b        = $signed(cb_ff);

endmodule

`default_nettype wire

[design/egcd_ctrl.sv]
// ----------------------------------------------------------------------------
// egcd_ctrl
// Sequencer for the Euclid iterations and the output handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "extended_gcd_inverse_unit_macros.svh"

module egcd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output egcd_pkg::cmd_type         cmd,
   input  wire egcd_pkg::status_type status
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CHECK = 5'b00010,
      S_DIV   = 5'b00100,
      S_UPD   = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type                   state_ff, state_in;
   logic [egcd_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        step_last;
   logic                        out_free;

   assign step_last = (cnt_ff == egcd_pkg::CNT_W'(egcd_pkg::WIDTH - 1));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      req_ready    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.lo_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (step_last) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            cmd.update = 1'b1;
            state_in   = S_CHECK;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `EGCD_ASSERT_NXT(a_div_to_upd, clock, reset, (state_ff == S_DIV) && step_last, state_ff == S_UPD)
   `EGCD_ASSERT_NXT(a_div_cnt_zero, clock, reset, (state_ff == S_CHECK) && !status.lo_zero, (state_ff == S_DIV) && (cnt_ff == '0))
   `EGCD_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.out_load, !rsp_valid_ff || rsp_ready)
   `EGCD_ASSERT_NXT(a_accept_check, clock, reset, req_valid && req_ready, state_ff == S_CHECK)

endmodule

`default_nettype wire

[design/extended_gcd_inverse_unit.sv]
// ----------------------------------------------------------------------------
// extended_gcd_inverse_unit
// Extended Euclidean GCD with Bezout coefficients and inverse-style fix-up.
// ----------------------------------------------------------------------------
// Usage: an item on req_ch carries operand_a and operand_b; the unit returns
// one item on rsp_ch with gcd_value, coeff_a and coeff_b. Both channels use
// valid/ready, and an item moves on a rising edge with both high.
// The unit works on one item at a time. req_ch.ready is high while the
// sequencer is idle, including while a finished item still waits in the
// output register.
// Operation: the operands are loaded at the accepting edge. Each Euclid
// iteration then runs a check state, 32 serial division steps and an update
// state, followed by a final check and the output state. rsp_ch.valid rises
// as the sequencer leaves the output state and returns to idle, ready for
// the next item. 32-bit operands need at most about 46 iterations. The
// bit-serial restoring divider dominates the run time: each step yields one
// quotient bit and folds it into the coefficient products.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// rsp_ch.valid; any item in flight is lost. If the receiver stalls, the
// result holds in the output register and the sequencer may take one further
// item, which then waits at its end until the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module extended_gcd_inverse_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   egcd_req_if.sink   req_ch,
   egcd_rsp_if.source rsp_ch
);

   // Command and status bundles between the sequencer and the datapath.
   egcd_pkg::cmd_type    cmd;
   egcd_pkg::status_type status;

   // The sequencer owns the handshakes and the output valid flag.
   egcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the operands, the coefficient pairs, the serial
   // divider and the registered result payload.
   egcd_datapath u_datapath (
      .clock     (clock),
      .operand_a (req_ch.operand_a),
      .operand_b (req_ch.operand_b),
      .cmd       (cmd),
      .status    (status),
      .gcd_value (rsp_ch.gcd_value),
      .coeff_a   (rsp_ch.coeff_a),
      .coeff_b   (rsp_ch.coeff_b)
   );

endmodule

`default_nettype wire
